@@ hdl/h2r_pkg.sv @@
// Shared types, constants and hue ramp helper for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

  typedef logic [15:0] pix16_t;

  // Hue position in thirds-scaled units: 3 * hue, one turn = 196608.
  typedef logic [17:0] pos_t;
  // Ramp weight, 0..32768 where 32768 = full step from p to q.
  typedef logic [15:0] weight_t;

  localparam pos_t TURN3   = 18'd196608;
  localparam pos_t THIRD3  = 18'd65536;
  localparam pos_t SIXTH3  = 18'd32768;
  localparam pos_t HALF3   = 18'd98304;
  localparam pos_t TWO3RD3 = 18'd131072;
  localparam logic [16:0] ONE = 17'd65535;

  // Per-stage load enables handed to the channel slices.
  typedef struct packed {
    logic s3;
    logic s4;
  } en_t;

  // Weight of q - p for a hue position inside one turn.
  function automatic weight_t ramp_weight(input pos_t pos);
    pos_t w;
    begin
      if (pos < SIXTH3) begin
        w = pos;
      end else if (pos < HALF3) begin
        w = SIXTH3;
      end else if (pos < TWO3RD3) begin
        w = TWO3RD3 - pos;
      end else begin
        w = '0;
      end
      ramp_weight = w[15:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/h2r_if.sv @@
// Valid/ready stream interfaces for HSL pixels in and RGB pixels out.
`default_nettype none

interface hsl_in_if;
  import h2r_pkg::*;
  logic   valid;
  logic   ready;
  pix16_t hue;
  pix16_t saturation;
  pix16_t lightness;
  pix16_t alpha_in;

  modport source (output valid, hue, saturation, lightness, alpha_in, input ready);
  modport sink   (input valid, hue, saturation, lightness, alpha_in, output ready);
endinterface

interface rgb_out_if;
  import h2r_pkg::*;
  logic   valid;
  logic   ready;
  pix16_t red;
  pix16_t green;
  pix16_t blue;
  pix16_t alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

@@ hdl/h2r_chan.sv @@
// One colour channel: ramp multiply, then add, clamp and grey select.
`default_nettype none

module h2r_chan (
  input  wire logic            clk,
  input  wire h2r_pkg::en_t    en,
  input  wire h2r_pkg::weight_t weight,
  input  wire logic signed [17:0] p,
  input  wire logic [16:0]     d,
  input  wire logic            grey,
  input  wire h2r_pkg::pix16_t lightness,
  output h2r_pkg::pix16_t      value
);
  import h2r_pkg::*;

  logic [32:0]        prod;
  logic signed [17:0] p3;
  logic signed [18:0] sum;
  pix16_t             value_next;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod <= 33'(d) * 33'(weight);
      p3   <= p;
    end
  end

  always_comb begin
    sum = 19'(p3) + $signed({1'b0, prod[32:15]});
    if (grey) begin
      value_next = lightness;
    end else if (sum < 0) begin
      value_next = '0;
    end else if (sum > $signed({2'b00, ONE})) begin
      value_next = ONE[15:0];
    end else begin
      value_next = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hsl_to_rgb_core.sv @@
// HSL to RGB pixel converter, four-stage pipeline.
// Throughput: one pixel per cycle while the output is ready; each stage advances on its own ready chain,
// so bubbles close up and input is taken while a result waits at the output.
// Stage 1 holds the L*S product, stage 3 the three 17x16 ramp products.
// Synchronous reset empties all stages; no other state.
`default_nettype none

module hsl_to_rgb_core (
  input  wire logic clk,
  input  wire logic rst,
  hsl_in_if.sink    pix_in,
  rgb_out_if.source pix_out
);
  import h2r_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  en_t  chan_en;

  // stage 1
  logic [31:0] prod1;
  pos_t        t3_1;
  pix16_t      l1, s1, a1;
  logic        grey1;

  // stage 2
  logic signed [17:0] p2;
  logic [16:0]        d2;
  weight_t            wr2, wg2, wb2;
  pix16_t             l2, a2;
  logic               grey2;

  // stage 3 / 4 side data
  pix16_t l3, a3, a4;
  logic   grey3;

  // stage 2 combinational
  logic [15:0]        est;
  logic [16:0]        rem;
  logic [16:0]        ls;
  logic signed [17:0] q_c, p_c;
  pos_t               pos_r, pos_b;

  assign en4 = !v4 || pix_out.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_in.ready = en1;
  assign chan_en.s3 = en3;
  assign chan_en.s4 = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pix_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod1 <= 32'(pix_in.lightness) * 32'(pix_in.saturation);
      t3_1  <= {2'b00, pix_in.hue} + {1'b0, pix_in.hue, 1'b0};
      l1    <= pix_in.lightness;
      s1    <= pix_in.saturation;
      a1    <= pix_in.alpha_in;
      grey1 <= (pix_in.saturation == '0);
    end
  end

  // floor(x / 65535): estimate x >> 16, remainder stays below 2 * 65535
  always_comb begin
    est = prod1[31:16];
    rem = {1'b0, prod1[15:0]} + {1'b0, est};
    ls  = {1'b0, est} + {16'd0, (rem >= ONE)};
    if (!l1[15]) begin
      q_c = $signed({2'b00, l1}) + $signed({1'b0, ls});
    end else begin
      q_c = $signed({2'b00, l1}) + $signed({2'b00, s1}) - $signed({1'b0, ls});
    end
    p_c = $signed({1'b0, l1, 1'b0}) - q_c;
    pos_r = (t3_1 + THIRD3 >= TURN3) ? t3_1 + THIRD3 - TURN3 : t3_1 + THIRD3;
    pos_b = (t3_1 >= THIRD3) ? t3_1 - THIRD3 : t3_1 + TWO3RD3;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p2    <= p_c;
      d2    <= (q_c > p_c) ? 17'(q_c - p_c) : '0;
      wr2   <= ramp_weight(pos_r);
      wg2   <= ramp_weight(t3_1);
      wb2   <= ramp_weight(pos_b);
      l2    <= l1;
      a2    <= a1;
      grey2 <= grey1;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      l3    <= l2;
      a3    <= a2;
      grey3 <= grey2;
    end
    if (en4) begin
      a4 <= a3;
    end
  end

  h2r_chan u_red (
    .clk(clk), .en(chan_en), .weight(wr2), .p(p2), .d(d2),
    .grey(grey3), .lightness(l3), .value(pix_out.red)
  );

  h2r_chan u_green (
    .clk(clk), .en(chan_en), .weight(wg2), .p(p2), .d(d2),
    .grey(grey3), .lightness(l3), .value(pix_out.green)
  );

  h2r_chan u_blue (
    .clk(clk), .en(chan_en), .weight(wb2), .p(p2), .d(d2),
    .grey(grey3), .lightness(l3), .value(pix_out.blue)
  );

  assign pix_out.valid     = v4;
  assign pix_out.alpha_out = a4;

  a_reset_empty: assert property (@(posedge clk) rst |=> !v1 && !v2 && !v3 && !v4)
    else $error("pipeline not empty after reset");

  a_bubble_accept: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2 || !v3 || !v4) |-> pix_in.ready)
    else $error("input stalled while a stage is empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && v3 && v4 && !pix_out.ready) |=> v2 && v3 && v4)
    else $error("stalled request lost from pipeline");

endmodule

`default_nettype wire
